// File: sv/text_console_char_writer_unit_assert.svh
// Assertion macros used by the console writer control module.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT_IMP(lbl, ante, cons, msg)
`define TCW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/tcw_pkg.sv
// Shared types, constants and address helper for the text console writer.
package tcw_pkg;

  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int SCREENS    = 3;
  localparam int TAB_STEP   = 8;
  localparam int CELLS      = SCREENS * ROWS * COLS;
  localparam int SCR_CELLS  = ROWS * COLS;
  localparam int COPY_CELLS = (ROWS - 1) * COLS;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [6:0] COL_LAST     = 7'(COLS - 1);
  localparam logic [4:0] ROW_LAST     = 5'(ROWS - 1);
  localparam logic [6:0] TAB_WRAP_COL = 7'((TAB_STEP < COLS) ? TAB_STEP : COLS - 1);
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [1:0] screen_index;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       did_scroll;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic read_done;
    logic scroll_step;
    logic clear_wr;
    logic cnt_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic bad_screen;
    logic need_scroll;
    logic cnt_last_clear;
    logic cnt_last_scroll;
  } ctl_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [1:0] s, logic [4:0] row,
                                                  logic [6:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(s) * ADDR_W'(SCR_CELLS) + ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

// File: sv/tcw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/tcw_ctrl.sv
// Sequencing state machine for the console writer.
`include "text_console_char_writer_unit_assert.svh"
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     out_valid
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last_clear) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.bad_screen) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.is_read) begin
          state_nxt = ST_READ;
        end else if (sts.need_scroll) begin
          state_nxt = ST_SCROLL;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.read_done = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.cnt_last_scroll) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last cell of the scroll pass (a blanked bottom-row cell) lands this cycle
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `TCW_ASSERT_NXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held twice")
  `TCW_ASSERT_IMP(a_exec_from_idle, state_r == ST_EXEC, $past(state_r) == ST_IDLE, "stray exec")
  `TCW_ASSERT_NXT(a_accept_exec, state_r == ST_IDLE && start, state_r == ST_EXEC, "accept lost")
  `TCW_ASSERT_IMP(a_flush_src, state_r == ST_FLUSH, $past(state_r) == ST_SCROLL, "stray flush")

endmodule

// File: sv/tcw_datapath.sv
// Cursors, attribute register, screen memory and the scroll copy pipeline.
module tcw_datapath import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  output out_item_t out_data
);

  in_item_t          req_r;
  out_item_t         res_r;
  logic [7:0]        attr_r;
  logic [6:0]        cur_x_r [SCREENS];
  logic [4:0]        cur_y_r [SCREENS];
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] base_r;
  logic              rd_ok_r;
  logic              pipe_v_r;
  logic              pipe_blank_r;
  logic [ADDR_W-1:0] pipe_wa_r;

  logic [1:0]        sel;
  logic              bad;
  logic              rd_ok;
  logic [6:0]        x, nx, adv_col, put_col;
  logic [4:0]        y, ny, put_row;
  logic [7:0]        put_chr;
  logic              put_we, adv, scroll;
  logic              scr_blank;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign bad   = (req_r.screen_index >= 2'(SCREENS));
  assign sel   = bad ? 2'd0 : req_r.screen_index;
  assign x     = cur_x_r[sel];
  assign y     = cur_y_r[sel];
  assign rd_ok = (req_r.read_row < 5'(ROWS)) && (req_r.read_col < 7'(COLS));

  // cursor motion for a put
  always_comb begin
    nx      = x;
    ny      = y;
    adv     = 1'b0;
    adv_col = '0;
    scroll  = 1'b0;
    put_we  = 1'b0;
    put_row = y;
    put_col = x;
    put_chr = req_r.char_code;
    case (req_r.char_code) inside
      CH_NEWLINE, CH_RETURN: begin
        adv = 1'b1;
      end
      CH_TAB: begin
        if (({1'b0, x} + 8'(TAB_STEP)) < 8'(COLS)) begin
          nx = 7'(x + 7'(TAB_STEP));
        end else begin
          adv     = 1'b1;
          adv_col = TAB_WRAP_COL;
        end
      end
      CH_BACKSPACE: begin
        if (x != '0) begin
          nx = x - 7'd1;
        end else if (y != '0) begin
          nx = COL_LAST;
          ny = y - 5'd1;
        end
        put_we  = 1'b1;
        put_row = ny;
        put_col = nx;
        put_chr = CH_SPACE;
      end
      default: begin
        put_we = 1'b1;
        if (x >= COL_LAST) begin
          adv = 1'b1;
        end else begin
          nx = x + 7'd1;
        end
      end
    endcase
    if (adv) begin
      if (({1'b0, y} + 6'd1) >= 6'(ROWS)) begin
        scroll = 1'b1;
        nx     = '0;
        ny     = ROW_LAST;
      end else begin
        nx = adv_col;
        ny = y + 5'd1;
      end
    end
  end

  assign sts.is_read         = (req_r.req_type == REQ_READ);
  assign sts.bad_screen      = bad;
  assign sts.need_scroll     = scroll;
  assign sts.cnt_last_clear  = (cnt_r == ADDR_W'(CELLS - 1));
  assign sts.cnt_last_scroll = (cnt_r == ADDR_W'(SCR_CELLS - 1));

  assign scr_blank = (cnt_r >= ADDR_W'(COPY_CELLS));

  // write port: copy pipeline, then clear pass, then put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = CH_SPACE;
    if (pipe_v_r) begin
      ram_we    = 1'b1;
      ram_waddr = pipe_wa_r;
      ram_wdata = pipe_blank_r ? CH_SPACE : ram_rdata;
    end else if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.exec && !bad && req_r.req_type == REQ_PUT && put_we) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(sel, put_row, put_col);
      ram_wdata = put_chr;
    end
  end

  always_comb begin
    if (cmd.scroll_step) begin
      ram_raddr = scr_blank ? base_r : base_r + ADDR_W'(COLS) + cnt_r;
    end else if (rd_ok) begin
      ram_raddr = cell_addr(sel, req_r.read_row, req_r.read_col);
    end else begin
      ram_raddr = '0;
    end
  end

  tcw_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r   <= ATTR_RESET;
      cnt_r    <= '0;
      pipe_v_r <= 1'b0;
      for (int i = 0; i < SCREENS; i++) begin
        cur_x_r[i] <= '0;
        cur_y_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clear_wr || cmd.scroll_step) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      pipe_v_r <= cmd.scroll_step;
      if (cmd.exec && !bad && req_r.req_type == REQ_PUT) begin
        cur_x_r[sel] <= nx;
        cur_y_r[sel] <= ny;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.scroll_step) begin
      pipe_wa_r    <= base_r + cnt_r;
      pipe_blank_r <= scr_blank;
    end
    if (cmd.exec) begin
      base_r  <= cell_addr(sel, 5'd0, 7'd0);
      rd_ok_r <= rd_ok;
      if (bad) begin
        res_r <= '0;
      end else if (req_r.req_type == REQ_READ) begin
        res_r.cursor_col <= x;
        res_r.cursor_row <= y;
        res_r.did_scroll <= 1'b0;
        res_r.cell_char  <= '0;
        res_r.cell_attr  <= '0;
      end else begin
        res_r.cursor_col <= nx;
        res_r.cursor_row <= ny;
        res_r.did_scroll <= scroll;
        res_r.cell_char  <= '0;
        res_r.cell_attr  <= '0;
      end
    end
    if (cmd.read_done && rd_ok_r) begin
      res_r.cell_char <= ram_rdata;
      res_r.cell_attr <= attr_r;
    end
  end

  assign out_data = res_r;

endmodule

// File: sv/text_console_char_writer_unit.sv
// Top level of the text console character writer.
// Three 80x25 text screens, each with its own cursor, in one 6000-byte memory.
// Input: a transaction is taken when start is high and busy is low; in_data carries
//   a put (char_code at the screen's cursor, with newline, return, tab and
//   backspace handling) or a read of one cell (read_row, read_col).
// Output: one result per transaction, out_data valid only in the cycle out_valid
//   is high. The receiver cannot stall; results must be taken when strobed.
// Sequence from the accepting edge to the strobe; a new transaction waits for IDLE:
//   put without scroll: IDLE, EXEC, then the registered strobe.
//   read: IDLE, EXEC, READ (registered memory read), then the strobe.
//   put that scrolls: EXEC, SCROLL, FLUSH; the memory port moves one cell a cycle to
//   shift 24 rows up and blank the bottom row.
// Reset (rst_n low, synchronous): cursors go to 0, the attribute to 7, and a
//   clearing pass writes spaces to all 6000 cells, one per cycle; busy stays
//   high until the pass ends. cfg_data writes the attribute whenever cfg_valid
//   is high outside reset (cfg_ready is always high), including during the pass.
module text_console_char_writer_unit import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .sts      (sts),
    .cmd      (cmd),
    .out_valid(out_valid)
  );

  tcw_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_data(out_data)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the three-screen text console character writer.
module tb_top import tcw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam int END_CYCLES  = 50;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  text_console_char_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Console shadow state
  logic [7:0] screen_text [SCREENS][ROWS][COLS];
  logic [6:0] shadow_col [SCREENS];
  logic [4:0] shadow_row [SCREENS];
  logic [7:0] shadow_attr;

  out_item_t  pending_results[$];
  int         mismatch_count;
  int         unexpected_count;
  int         cycle_count;
  int         request_count;
  int         read_count;
  int         scroll_count;
  int         attr_writes;
  int         text_screen;

  function automatic void clear_console();
    for (int s = 0; s < SCREENS; s++) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          screen_text[s][r][c] = CH_SPACE;
        end
      end
      shadow_col[s] = '0;
      shadow_row[s] = '0;
    end
    shadow_attr = ATTR_RESET;
  endfunction

  // Applies one request to the shadow console and returns the expected result.
  function automatic out_item_t console_step(in_item_t it);
    out_item_t res;
    int s, x, y;
    logic scrolled;
    res = '0;
    scrolled = 1'b0;
    if (it.screen_index >= SCREENS) begin
      return res;
    end
    s = it.screen_index;
    x = shadow_col[s];
    y = shadow_row[s];
    if (it.req_type == REQ_PUT) begin
      if (it.char_code == CH_NEWLINE || it.char_code == CH_RETURN) begin
        x = 0;
        y++;
      end else if (it.char_code == CH_TAB) begin
        if (x + TAB_STEP < COLS) begin
          x = x + TAB_STEP;
        end else begin
          x = TAB_WRAP_COL;
          y++;
        end
      end else if (it.char_code == CH_BACKSPACE) begin
        if (x > 0) begin
          x--;
        end else if (y > 0) begin
          x = COLS - 1;
          y--;
        end
        screen_text[s][y][x] = CH_SPACE;
      end else begin
        screen_text[s][y][x] = it.char_code;
        if (x >= COLS - 1) begin
          x = 0;
          y++;
        end else begin
          x++;
        end
      end
      if (y >= ROWS) begin
        for (int r = 0; r < ROWS - 1; r++) begin
          for (int c = 0; c < COLS; c++) begin
            screen_text[s][r][c] = screen_text[s][r+1][c];
          end
        end
        for (int c = 0; c < COLS; c++) begin
          screen_text[s][ROWS-1][c] = CH_SPACE;
        end
        x = 0;
        y = ROWS - 1;
        scrolled = 1'b1;
      end
    end else if (it.read_row < ROWS && it.read_col < COLS) begin
      res.cell_char = screen_text[s][it.read_row][it.read_col];
      res.cell_attr = shadow_attr;
    end
    shadow_col[s]  = 7'(x);
    shadow_row[s]  = 5'(y);
    res.cursor_col = 7'(x);
    res.cursor_row = 5'(y);
    res.did_scroll = scrolled;
    return res;
  endfunction

  function automatic in_item_t put_req(int s, logic [7:0] ch);
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_type     = REQ_PUT;
    it.screen_index = 2'(s);
    it.char_code    = ch;
    return it;
  endfunction

  function automatic in_item_t read_req(int s, int row, int col);
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_type     = REQ_READ;
    it.screen_index = 2'(s);
    it.read_row     = 5'(row);
    it.read_col     = 7'(col);
    return it;
  endfunction

  // Mixed traffic: reads anywhere (some out of range), control bytes, any byte.
  function automatic in_item_t random_request();
    in_item_t it;
    int pick, s;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 24) == 0) ? 3 : $urandom_range(0, SCREENS - 1);
    if (pick < 28) begin
      if ($urandom_range(0, 9) == 0) begin
        it = read_req(s, $urandom_range(0, 31), $urandom_range(0, 127));
      end else begin
        it = read_req(s, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
      end
    end else if (pick < 38) begin
      it = put_req(s, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN);
    end else if (pick < 46) begin
      it = put_req(s, CH_TAB);
    end else if (pick < 54) begin
      it = put_req(s, CH_BACKSPACE);
    end else begin
      it = put_req(s, 8'($urandom_range(0, 255)));
    end
    return it;
  endfunction

  // Text lines aimed mostly at one screen so it fills up and keeps scrolling.
  function automatic in_item_t text_request();
    in_item_t it;
    int pick, s;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SCREENS - 1) : text_screen;
    if (pick < 12) begin
      it = put_req(s, CH_NEWLINE);
      if ($urandom_range(0, 3) == 0) begin
        text_screen = $urandom_range(0, SCREENS - 1);
      end
    end else if (pick < 18) begin
      it = put_req(s, CH_TAB);
    end else if (pick < 22) begin
      it = put_req(s, CH_BACKSPACE);
    end else if (pick < 30) begin
      it = read_req(s, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
    end else begin
      it = put_req(s, 8'($urandom_range(8'h21, 8'h7e)));
    end
    return it;
  endfunction

  // Drives one request at the falling edge and holds it until accepted.
  task automatic send_item(in_item_t it, int max_gap);
    int gap;
    out_item_t res;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_data = it;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    res = console_step(it);
    pending_results.push_back(res);
    request_count++;
    if (it.req_type == REQ_READ) read_count++;
    if (res.did_scroll) scroll_count++;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_attribute(logic [7:0] value);
    wait_results_done();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    shadow_attr = value;
    attr_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(read_req(0, 0, 0), 3);
    send_item(put_req(0, CH_BACKSPACE), 3);      // top-left: cursor stays
    send_item(put_req(0, 8'hff), 3);
    send_item(put_req(0, 8'h00), 3);
    send_item(read_req(0, 0, 0), 3);
    send_item(read_req(0, 0, 1), 3);
    send_item(put_req(0, CH_TAB), 3);
    send_item(put_req(0, CH_NEWLINE), 3);
    send_item(put_req(0, CH_RETURN), 3);
    send_item(put_req(3, 8'h41), 3);             // no such screen
    send_item(read_req(3, 0, 0), 3);
    send_item(read_req(1, 31, 127), 3);          // read outside the screen
    send_item(read_req(2, ROWS - 1, COLS - 1), 3);
    send_item(read_req(2, ROWS, 0), 3);
    send_item(read_req(2, 0, COLS), 3);
    send_item(put_req(0, CH_BACKSPACE), 3);      // back across the row edge
    send_item(put_req(0, 8'h5a), 3);             // last column, wraps
    send_item(put_req(0, CH_BACKSPACE), 3);
    send_item(put_req(0, CH_TAB), 3);            // tab wraps to next row
    send_item(read_req(0, 1, COLS - 1), 3);
  endtask

  task automatic test_random_mix(int count, int max_gap);
    for (int i = 0; i < count; i++) begin
      send_item(random_request(), max_gap);
    end
  endtask

  task automatic test_scrolling_text(int count, int max_gap);
    text_screen = 1;
    for (int i = 0; i < count; i++) begin
      send_item(text_request(), max_gap);
    end
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        unexpected_count++;
        $display("[%0t] result with no request outstanding", $realtime);
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_col", 8'(want.cursor_col), 8'(out_data.cursor_col));
        check_field("cursor_row", 8'(want.cursor_row), 8'(out_data.cursor_row));
        check_field("did_scroll", 8'(want.did_scroll), 8'(out_data.did_scroll));
        check_field("cell_char", want.cell_char, out_data.cell_char);
        check_field("cell_attr", want.cell_attr, out_data.cell_attr);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    mismatch_count   = 0;
    unexpected_count = 0;
    cycle_count      = 0;
    request_count    = 0;
    read_count       = 0;
    scroll_count     = 0;
    attr_writes      = 0;
    text_screen      = 1;
    clear_console();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    set_attribute(8'h00);
    test_random_mix(350, 15);
    set_attribute(8'hff);
    test_scrolling_text(400, 15);
    set_attribute(8'($urandom_range(1, 254)));
    test_random_mix(300, 0);
    set_attribute(8'($urandom_range(0, 255)));
    test_random_mix(250, 15);

    wait_results_done();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    $display("Sent %0d requests (%0d reads, %0d scrolling puts) over %0d attribute values",
             request_count, read_count, scroll_count, attr_writes + 1);
    $display("Mismatches: %0d, unexpected results: %0d", mismatch_count, unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
